FILE: sv/irenc_pkg.sv
// Shared types, constants and helpers for the IR mark/space encoder.
// Used by every module of the encoder and by its channel interfaces.
`default_nettype none

package irenc_pkg;

    // Duration saturation width (segments never exceed 16 bits)
    localparam int DURATION_BITS = 16;

    localparam int DUR_W     = 16;
    localparam int RAW_W     = 17;
    localparam int CYC_W     = 16;
    localparam int PULSE_W   = 8;
    localparam int PERIOD_W  = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Dividend is duration * 256 plus half the period
    localparam int NUM_W  = DUR_W + 8 + 1;
    localparam int HEAD_W = NUM_W - CYC_W;

    // One divider cell per quotient bit
    localparam int DIV_CELLS = CYC_W;

    localparam logic [DUR_W:0] DUR_LIM = (DURATION_BITS >= DUR_W) ?
        {1'b0, {DUR_W{1'b1}}} : (DUR_W + 1)'((64'd1 << DURATION_BITS) - 64'd1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODING_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_SLOT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_SEGMENT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SEGMENT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SEGMENT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_HIGH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER_LOW    = 3'd7;

    // Coding modes
    localparam logic [MODE_W-1:0] MODE_BIPHASE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISTANCE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LENGTH   = 2'd2;

    // Item kinds
    localparam logic KIND_RAW = 1'b0;
    localparam logic KIND_BIT = 1'b1;

    typedef struct packed {
        logic [MODE_W-1:0]   coding_mode;
        logic [DUR_W-1:0]    bit_slot_us;
        logic [DUR_W-1:0]    fixed_segment_us;
        logic [DUR_W-1:0]    zero_segment_us;
        logic [DUR_W-1:0]    one_segment_us;
        logic [PERIOD_W-1:0] carrier_period_q8;
        logic [PULSE_W-1:0]  carrier_high_us;
        logic [PULSE_W-1:0]  carrier_low_us;
    } cfg_t;

    // Up to two segments produced by one item
    typedef struct packed {
        logic             level0;
        logic [DUR_W-1:0] dur0;
        logic             level1;
        logic [DUR_W-1:0] dur1;
        logic             two;
    } seg_pair_t;

    // Beat travelling down the divider chain
    typedef struct packed {
        logic                ovf;
        logic [PERIOD_W-1:0] rem;
        logic [CYC_W-1:0]    num;
        seg_pair_t           seg;
    } div_t;

    function automatic logic [DUR_W-1:0] sat_dur(input logic [DUR_W:0] d);
        logic [DUR_W:0] r;
        r = (d > DUR_LIM) ? DUR_LIM : d;
        return r[DUR_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/irenc_if.sv
// Channel interfaces of the IR mark/space encoder: input items and segments.
// Depends on irenc_pkg for field widths.
`default_nettype none

interface irenc_item_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic signed [irenc_pkg::RAW_W-1:0] raw_duration_us;
    logic                              bit_value;

    modport source (output valid, kind, raw_duration_us, bit_value, input ready);
    modport sink   (input valid, kind, raw_duration_us, bit_value, output ready);
endinterface

interface irenc_seg_if;
    logic                              valid;
    logic                              ready;
    logic                              level;
    logic [irenc_pkg::DUR_W-1:0]       duration_us;
    logic [irenc_pkg::CYC_W-1:0]       carrier_cycles;
    logic [irenc_pkg::PULSE_W-1:0]     pulse_high_us;
    logic [irenc_pkg::PULSE_W-1:0]     pulse_low_us;
    logic                              last;

    modport source (output valid, level, duration_us, carrier_cycles, pulse_high_us,
                    pulse_low_us, last, input ready);
    modport sink   (input valid, level, duration_us, carrier_cycles, pulse_high_us,
                    pulse_low_us, last, output ready);
endinterface

`default_nettype wire

FILE: sv/irenc_cfg.sv
// Configuration register file of the IR mark/space encoder.
// Depends on irenc_pkg.
`default_nettype none

module irenc_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [irenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [irenc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output irenc_pkg::cfg_t                          cfg
);
    import irenc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CODING_MODE:    cfg_next.coding_mode       = cfg_wr_data[MODE_W-1:0];
                REG_BIT_SLOT:       cfg_next.bit_slot_us       = cfg_wr_data;
                REG_FIXED_SEGMENT:  cfg_next.fixed_segment_us  = cfg_wr_data;
                REG_ZERO_SEGMENT:   cfg_next.zero_segment_us   = cfg_wr_data;
                REG_ONE_SEGMENT:    cfg_next.one_segment_us    = cfg_wr_data;
                REG_CARRIER_PERIOD: cfg_next.carrier_period_q8 = cfg_wr_data;
                REG_CARRIER_HIGH:   cfg_next.carrier_high_us   = cfg_wr_data[PULSE_W-1:0];
                REG_CARRIER_LOW:    cfg_next.carrier_low_us    = cfg_wr_data[PULSE_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold settings, load defaults at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coding_mode       <= MODE_BIPHASE;
            cfg_reg.bit_slot_us       <= 16'd1780;
            cfg_reg.fixed_segment_us  <= 16'd563;
            cfg_reg.zero_segment_us   <= 16'd562;
            cfg_reg.one_segment_us    <= 16'd1688;
            cfg_reg.carrier_period_q8 <= 16'd6737;
            cfg_reg.carrier_high_us   <= 8'd9;
            cfg_reg.carrier_low_us    <= 8'd17;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/irenc_front.sv
// Front stage: turns an input item into its segment pair and seeds the divider.
// Depends on irenc_pkg.
`default_nettype none

module irenc_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  adv,
    input  wire irenc_pkg::cfg_t                       cfg,
    input  wire logic                                  take,
    input  wire logic                                  kind,
    input  wire logic signed [irenc_pkg::RAW_W-1:0]    raw_duration_us,
    input  wire logic                                  bit_value,
    output logic                                       valid,
    output irenc_pkg::div_t                            data
);
    import irenc_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    div_t             data_reg;
    div_t             data_next;

    seg_pair_t        seg;
    logic             has_result;
    logic [DUR_W-1:0] mark_dur;
    logic [DUR_W:0]   raw_mag;
    logic [DUR_W-1:0] half_hi;
    logic [DUR_W-1:0] half_lo;
    logic [DUR_W-1:0] var_dur;
    logic [DUR_W-1:0] fixed_dur;
    logic [NUM_W-1:0] dividend;
    logic [HEAD_W-1:0] head;

    // Build the segment pair for this item
    always_comb
    begin
        raw_mag    = raw_duration_us[RAW_W-1] ? (DUR_W + 1)'(-raw_duration_us)
                                              : (DUR_W + 1)'(raw_duration_us);
        half_hi    = sat_dur(({1'b0, cfg.bit_slot_us} + (DUR_W + 1)'(1)) >> 1);
        half_lo    = sat_dur({1'b0, cfg.bit_slot_us} >> 1);
        var_dur    = sat_dur({1'b0, bit_value ? cfg.one_segment_us : cfg.zero_segment_us});
        fixed_dur  = sat_dur({1'b0, cfg.fixed_segment_us});
        seg        = '0;
        has_result = 1'b1;
        mark_dur   = '0;
        if (kind == KIND_RAW)
        begin
            seg.level0 = !raw_duration_us[RAW_W-1];
            seg.dur0   = sat_dur(raw_mag);
            mark_dur   = seg.level0 ? seg.dur0 : '0;
        end
        else
        begin
            seg.two = 1'b1;
            unique case (cfg.coding_mode)
                MODE_BIPHASE:
                begin
                    seg.level0 = !bit_value;
                    seg.dur0   = half_hi;
                    seg.level1 = bit_value;
                    seg.dur1   = half_lo;
                    mark_dur   = bit_value ? half_lo : half_hi;
                end
                MODE_DISTANCE:
                begin
                    seg.level0 = 1'b1;
                    seg.dur0   = fixed_dur;
                    seg.dur1   = var_dur;
                    mark_dur   = fixed_dur;
                end
                MODE_LENGTH:
                begin
                    seg.level0 = 1'b1;
                    seg.dur0   = var_dur;
                    seg.dur1   = fixed_dur;
                    mark_dur   = var_dur;
                end
                default:
                begin
                    has_result = 1'b0;
                end
            endcase
        end
    end

    // Seed the divider: duration * 256 + period / 2, split into head and body
    always_comb
    begin
        dividend       = NUM_W'({mark_dur, 8'h00}) + NUM_W'(cfg.carrier_period_q8 >> 1);
        head           = dividend[NUM_W-1:CYC_W];
        data_next.ovf  = PERIOD_W'(head) >= cfg.carrier_period_q8;
        data_next.rem  = PERIOD_W'(head);
        data_next.num  = dividend[CYC_W-1:0];
        data_next.seg  = seg;
        valid_next     = take && has_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/irenc_cell.sv
// Divider cell: one restoring division step, one quotient bit per cell.
// Depends on irenc_pkg.
`default_nettype none

module irenc_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               adv,
    input  wire logic [irenc_pkg::PERIOD_W-1:0]     period,
    input  wire logic                               in_valid,
    input  wire irenc_pkg::div_t                    in_data,
    output logic                                    out_valid,
    output irenc_pkg::div_t                         out_data
);
    import irenc_pkg::*;

    logic              valid_reg;
    div_t              data_reg;
    div_t              data_next;
    logic [PERIOD_W:0] trial;
    logic [PERIOD_W:0] diff;
    logic              ge;

    // Shift in the next dividend bit, subtract the period when it fits
    always_comb
    begin
        trial     = {in_data.rem, in_data.num[CYC_W-1]};
        diff      = trial - {1'b0, period};
        ge        = trial >= {1'b0, period};
        data_next = in_data;
        data_next.rem = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
        data_next.num = {in_data.num[CYC_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

FILE: sv/irenc_out.sv
// Output stage: splits a finished segment pair into beats on the segment channel.
// Depends on irenc_pkg and irenc_seg_if.
`default_nettype none

module irenc_out (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire irenc_pkg::cfg_t    cfg,
    input  wire logic               tail_valid,
    input  wire irenc_pkg::div_t    tail_data,
    output logic                    adv,
    irenc_seg_if.source             segment
);
    import irenc_pkg::*;

    logic               idx_reg;
    logic               idx_next;
    logic               ov_reg;
    logic               ov_next;
    logic               level_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [CYC_W-1:0]   cyc_reg;
    logic [PULSE_W-1:0] hi_reg;
    logic [PULSE_W-1:0] lo_reg;
    logic               last_reg;

    logic               load;
    logic               cur_level;
    logic [DUR_W-1:0]   cur_dur;
    logic               cur_last;
    logic [CYC_W-1:0]   quot;

    // Pick the segment to send next
    always_comb
    begin
        load      = !ov_reg || segment.ready;
        cur_level = idx_reg ? tail_data.seg.level1 : tail_data.seg.level0;
        cur_dur   = idx_reg ? tail_data.seg.dur1 : tail_data.seg.dur0;
        cur_last  = !tail_data.seg.two || idx_reg;
        quot      = tail_data.ovf ? {CYC_W{1'b1}} : tail_data.num;
        adv       = !tail_valid || (load && cur_last);
        ov_next   = load ? tail_valid : ov_reg;
        idx_next  = idx_reg;
        if (load && tail_valid)
        begin
            idx_next = !cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg  <= 1'b0;
            idx_reg <= 1'b0;
        end
        else
        begin
            ov_reg  <= ov_next;
            idx_reg <= idx_next;
        end
    end

    // Load the output register when it is free or being taken
    always_ff @(posedge clk)
    begin
        if (load && tail_valid)
        begin
            level_reg <= cur_level;
            dur_reg   <= cur_dur;
            cyc_reg   <= cur_level ? quot : '0;
            hi_reg    <= cur_level ? cfg.carrier_high_us : '0;
            lo_reg    <= cur_level ? cfg.carrier_low_us : '0;
            last_reg  <= cur_last;
        end
    end

    assign segment.valid          = ov_reg;
    assign segment.level          = level_reg;
    assign segment.duration_us    = dur_reg;
    assign segment.carrier_cycles = cyc_reg;
    assign segment.pulse_high_us  = hi_reg;
    assign segment.pulse_low_us   = lo_reg;
    assign segment.last           = last_reg;

endmodule

`default_nettype wire

FILE: sv/ir_bit_to_mark_space_encoder.sv
// IR transmit encoder: turns raw segments and data bits into mark/space beats.
//
// Input channel "item": a raw signed segment (kind 0) or one data bit (kind 1).
// Output channel "segment": one beat per mark or space, with its duration,
// the rounded carrier cycle count and carrier on/off times for marks, and
// last set on the final beat of an item. A data bit gives two beats, a raw
// segment one, a data bit in the unused coding mode none.
// From item acceptance to the first segment beat: one front stage, a chain of
// 16 divider cells (one quotient bit each) for the carrier count, and the
// output register. Throughput: while the receiver takes beats, the chain takes
// a new item every cycle and the output register one beat per cycle; raw
// segments run at one per cycle; a data bit holds the chain for its second beat.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wr_data; the user
// must do so only while idle, as the block itself does not enforce it.
// Reset (rst_n low, asynchronous) empties the chain and loads default settings.
// When the receiver stalls, the output register holds its beat and the whole
// chain freezes once its tail is waiting, and item.ready drops with it.
// Depends on irenc_pkg, irenc_if, irenc_cfg, irenc_front, irenc_cell, irenc_out.
`default_nettype none

module ir_bit_to_mark_space_encoder (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [irenc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [irenc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    irenc_item_if.sink                               item,
    irenc_seg_if.source                              segment
);
    import irenc_pkg::*;

    cfg_t cfg;
    logic adv;
    logic take;
    logic stg_valid [DIV_CELLS+1];
    div_t stg_data  [DIV_CELLS+1];

    irenc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // Accept whenever the chain moves
    assign item.ready = adv;
    assign take       = item.valid && adv;

    irenc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .cfg             (cfg),
        .take            (take),
        .kind            (item.kind),
        .raw_duration_us (item.raw_duration_us),
        .bit_value       (item.bit_value),
        .valid           (stg_valid[0]),
        .data            (stg_data[0])
    );

    // Divider chain
    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        irenc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .period    (cfg.carrier_period_q8),
            .in_valid  (stg_valid[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    irenc_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tail_valid (stg_valid[DIV_CELLS]),
        .tail_data  (stg_data[DIV_CELLS]),
        .adv        (adv),
        .segment    (segment)
    );

    // A space carries no carrier information
    a_space_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        segment.valid && !segment.level |->
            segment.carrier_cycles == '0 && segment.pulse_high_us == '0 &&
            segment.pulse_low_us == '0)
        else $error("space beat with carrier fields set");

    // The second beat of a pair always follows the first
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        segment.valid && !segment.last |=> segment.valid)
        else $error("first beat of a pair without its partner");

    // A frozen chain holds its front stage
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(stg_valid[0]))
        else $error("front stage changed while the chain was stalled");

endmodule

`default_nettype wire

FILE: sim/irenc_segment_checker.sv
`timescale 1ns / 100ps
// Segment checker for the IR mark/space encoder: mirrors the registers from the
// write port, predicts the beats of every accepted item and compares them in order.
// Depends on irenc_pkg and the channel interfaces in irenc_if.
module irenc_segment_checker
    import irenc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    irenc_item_if                      item,
    irenc_seg_if                       segment,
    output int                         outstanding,
    output int                         fail_count
);

    typedef struct packed {
        logic               level;
        logic [DUR_W-1:0]   duration_us;
        logic [CYC_W-1:0]   carrier_cycles;
        logic [PULSE_W-1:0] pulse_high_us;
        logic [PULSE_W-1:0] pulse_low_us;
        logic               last;
    } seg_beat_t;

    localparam cfg_t SETTINGS_AT_RESET = '{
        coding_mode:       MODE_BIPHASE,
        bit_slot_us:       16'd1780,
        fixed_segment_us:  16'd563,
        zero_segment_us:   16'd562,
        one_segment_us:    16'd1688,
        carrier_period_q8: 16'd6737,
        carrier_high_us:   8'd9,
        carrier_low_us:    8'd17
    };

    cfg_t      regs;
    seg_beat_t expected_beats[$];

    initial begin
        outstanding = 0;
        fail_count  = 0;
    end

    // Clip a duration to the longest segment the block can report
    function automatic logic [DUR_W-1:0] clamp_duration(input int unsigned d);
        int unsigned limit;
        limit = (DURATION_BITS >= 16) ? 32'd65535 : (32'd1 << DURATION_BITS) - 32'd1;
        return (d > limit) ? DUR_W'(limit) : DUR_W'(d);
    endfunction

    // Build one beat; marks carry the rounded carrier count and the pulse times
    function automatic seg_beat_t shape_beat(input logic mark, input int unsigned d,
                                             input logic last);
        seg_beat_t   b;
        int unsigned dur;
        int unsigned period;
        int unsigned cycles;
        dur    = clamp_duration(d);
        period = regs.carrier_period_q8;
        cycles = 0;
        if (mark) begin
            if (period == 0)
                cycles = 65535;
            else
                cycles = (dur * 256 + period / 2) / period;
            if (cycles > 65535)
                cycles = 65535;
        end
        b.level          = mark;
        b.duration_us    = DUR_W'(dur);
        b.carrier_cycles = CYC_W'(cycles);
        b.pulse_high_us  = mark ? regs.carrier_high_us : '0;
        b.pulse_low_us   = mark ? regs.carrier_low_us : '0;
        b.last           = last;
        return b;
    endfunction

    // Append one beat at the tail of the expected stream
    function automatic void queue_beat(input seg_beat_t b);
        expected_beats = {expected_beats, b};
    endfunction

    // Queue the beats one item causes under the current settings
    task automatic predict_segments(input logic kind, input logic [RAW_W-1:0] raw,
                                    input logic bit_value);
        int unsigned half_up;
        int unsigned half_down;
        int unsigned variable_us;
        half_down   = regs.bit_slot_us / 2;
        half_up     = regs.bit_slot_us - half_down;
        variable_us = bit_value ? regs.one_segment_us : regs.zero_segment_us;
        if (kind == KIND_RAW) begin
            // negative durations are spaces of the magnitude
            if (raw[RAW_W-1])
                queue_beat(shape_beat(1'b0, 32'h20000 - raw, 1'b1));
            else
                queue_beat(shape_beat(1'b1, raw, 1'b1));
        end else begin
            case (regs.coding_mode)
                MODE_BIPHASE: begin
                    queue_beat(shape_beat(!bit_value, half_up, 1'b0));
                    queue_beat(shape_beat(bit_value, half_down, 1'b1));
                end
                MODE_DISTANCE: begin
                    queue_beat(shape_beat(1'b1, regs.fixed_segment_us, 1'b0));
                    queue_beat(shape_beat(1'b0, variable_us, 1'b1));
                end
                MODE_LENGTH: begin
                    queue_beat(shape_beat(1'b1, variable_us, 1'b0));
                    queue_beat(shape_beat(1'b0, regs.fixed_segment_us, 1'b1));
                end
                default: ; // unused mode drops the bit
            endcase
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Track register writes, check leaving beats, predict entering items
    always @(posedge clk or negedge rst_n) begin : watch
        seg_beat_t want;
        if (!rst_n) begin
            regs = SETTINGS_AT_RESET;
            expected_beats.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CODING_MODE:    regs.coding_mode       = cfg_wr_data[MODE_W-1:0];
                    REG_BIT_SLOT:       regs.bit_slot_us       = cfg_wr_data[DUR_W-1:0];
                    REG_FIXED_SEGMENT:  regs.fixed_segment_us  = cfg_wr_data[DUR_W-1:0];
                    REG_ZERO_SEGMENT:   regs.zero_segment_us   = cfg_wr_data[DUR_W-1:0];
                    REG_ONE_SEGMENT:    regs.one_segment_us    = cfg_wr_data[DUR_W-1:0];
                    REG_CARRIER_PERIOD: regs.carrier_period_q8 = cfg_wr_data[PERIOD_W-1:0];
                    REG_CARRIER_HIGH:   regs.carrier_high_us   = cfg_wr_data[PULSE_W-1:0];
                    REG_CARRIER_LOW:    regs.carrier_low_us    = cfg_wr_data[PULSE_W-1:0];
                    default: ;
                endcase
            end
            if (segment.valid && segment.ready) begin
                if (expected_beats.size() == 0) begin
                    $error("segment beat with nothing pending: level %0d duration %0d",
                           segment.level, segment.duration_us);
                    fail_count++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("level", want.level, segment.level);
                    compare_field("duration_us", want.duration_us, segment.duration_us);
                    compare_field("carrier_cycles", want.carrier_cycles,
                                  segment.carrier_cycles);
                    compare_field("pulse_high_us", want.pulse_high_us, segment.pulse_high_us);
                    compare_field("pulse_low_us", want.pulse_low_us, segment.pulse_low_us);
                    compare_field("last", want.last, segment.last);
                end
            end
            if (item.valid && item.ready)
                predict_segments(item.kind, item.raw_duration_us, item.bit_value);
        end
        outstanding = expected_beats.size();
    end

endmodule

FILE: sim/tb_ir_bit_to_mark_space_encoder.sv
`timescale 1ns / 100ps
// Testbench top for the IR mark/space encoder: clock, reset, register writes,
// item stimulus and receiver stalls; the verdict comes from irenc_segment_checker.
// Depends on irenc_pkg, irenc_if, ir_bit_to_mark_space_encoder and the checker.
module tb_ir_bit_to_mark_space_encoder;
    import irenc_pkg::*;

    localparam int ITEM_TARGET       = 1150;
    localparam int SETTLE_CYCLES     = 24;
    localparam int LONG_STALL_CYCLES = 200;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    int                    send_idle_pct = 32;
    int                    recv_idle_pct = 62;
    int                    items_sent    = 0;
    int                    outstanding;
    int                    fail_count;
    bit                    stall_request = 1'b0;

    irenc_item_if item_ch ();
    irenc_seg_if  seg_ch ();

    ir_bit_to_mark_space_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .segment     (seg_ch)
    );

    irenc_segment_checker seg_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .segment     (seg_ch),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

    // Drive segment ready; honor a long hold-off when one is requested
    initial
    begin : receiver
        seg_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                seg_ch.ready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(posedge clk);
                stall_request = 1'b0;
            end
            seg_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic cfg_t make_settings(input logic [MODE_W-1:0] mode,
                                           input logic [15:0] slot, input logic [15:0] fixed,
                                           input logic [15:0] zero, input logic [15:0] one,
                                           input logic [15:0] period,
                                           input logic [7:0] high, input logic [7:0] low);
        cfg_t s;
        s.coding_mode       = mode;
        s.bit_slot_us       = slot;
        s.fixed_segment_us  = fixed;
        s.zero_segment_us   = zero;
        s.one_segment_us    = one;
        s.carrier_period_q8 = period;
        s.carrier_high_us   = high;
        s.carrier_low_us    = low;
        return s;
    endfunction

    // Random 16-bit value that often lands on or near an extreme
    function automatic logic [15:0] pick_u16();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 3));
            3: return 16'hFFFF - 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item beat and return at the edge that accepts it
    task automatic send_item(input logic kind, input logic [RAW_W-1:0] raw,
                             input logic bit_value);
        send_idle_pct = (items_sent < 400) ? 32 : (items_sent < 800) ? 62 : 0;
        recv_idle_pct = (items_sent < 400) ? 62 : (items_sent < 800) ? 32 : 0;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.kind            <= kind;
        item_ch.raw_duration_us <= raw;
        item_ch.bit_value       <= bit_value;
        do @(negedge clk); while (!item_ch.ready);
        @(posedge clk);
        items_sent++;
    endtask

    // Drop valid, wait for every pending beat, then let the pipeline drain
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all eight registers; unused upper data bits carry noise
    task automatic program_settings(input cfg_t s);
        logic [CFG_DATA_W-1:0] values [8];
        logic [CFG_DATA_W-1:0] noise;
        noise = CFG_DATA_W'($urandom);
        values[REG_CODING_MODE]    = {noise[CFG_DATA_W-1:MODE_W], s.coding_mode};
        values[REG_BIT_SLOT]       = s.bit_slot_us;
        values[REG_FIXED_SEGMENT]  = s.fixed_segment_us;
        values[REG_ZERO_SEGMENT]   = s.zero_segment_us;
        values[REG_ONE_SEGMENT]    = s.one_segment_us;
        values[REG_CARRIER_PERIOD] = s.carrier_period_q8;
        values[REG_CARRIER_HIGH]   = {noise[CFG_DATA_W-1:PULSE_W], s.carrier_high_us};
        values[REG_CARRIER_LOW]    = {noise[PULSE_W-1:0], s.carrier_low_us};
        for (int i = 0; i < 8; i++)
        begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= CFG_IDX_W'(i);
            cfg_wr_data <= values[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : stimulus
        int                  phase;
        int                  burst;
        logic [RAW_W-1:0]    raw;
        logic [MODE_W-1:0]   mode;
        logic [15:0]         period;

        rst_n                   <= 1'b0;
        cfg_wr_en               <= 1'b0;
        cfg_index               <= REG_CODING_MODE;
        cfg_wr_data             <= '0;
        item_ch.valid           <= 1'b0;
        item_ch.kind            <= KIND_RAW;
        item_ch.raw_duration_us <= '0;
        item_ch.bit_value       <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: raw zero, largest mark, most negative space, bi-phase bits
        send_item(KIND_RAW, 17'h00000, 1'b0);
        send_item(KIND_RAW, 17'h0FFFF, 1'b1);
        send_item(KIND_RAW, 17'h10000, 1'b0);
        send_item(KIND_RAW, 17'h1FFFF, 1'b1);
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h1FFFF, 1'b1);
        send_item(KIND_RAW, 17'h15555, 1'b1);
        send_item(KIND_BIT, 17'h0AAAA, 1'b1);

        // Pulse distance at the field extremes, one carrier cycle per microsecond
        wait_idle();
        program_settings(make_settings(MODE_DISTANCE, 16'd2, 16'hFFFF, 16'd0, 16'hFFFF,
                                       16'd256, 8'hFF, 8'h00));
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h00000, 1'b1);
        send_item(KIND_RAW, 17'h0FFFF, 1'b0);

        // Pulse length with a zero carrier period
        wait_idle();
        program_settings(make_settings(MODE_LENGTH, 16'hFFFF, 16'd0, 16'd1, 16'hFFFE,
                                       16'd0, 8'h00, 8'hFF));
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h00000, 1'b1);
        send_item(KIND_RAW, 17'h0012C, 1'b0);
        send_item(KIND_RAW, 17'h1FED4, 1'b0);

        // Unused mode drops bits; raw marks saturate the carrier count
        wait_idle();
        program_settings(make_settings(MODE_UNUSED, 16'd1780, 16'd563, 16'd562, 16'd1688,
                                       16'd1, 8'd9, 8'd17));
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h00000, 1'b1);
        send_item(KIND_RAW, 17'h0FFFF, 1'b0);
        send_item(KIND_BIT, 17'h0FFFF, 1'b1);

        // Tiny and huge bi-phase slots
        wait_idle();
        program_settings(make_settings(MODE_BIPHASE, 16'd0, 16'd563, 16'd562, 16'd1688,
                                       16'd6737, 8'd9, 8'd17));
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h00000, 1'b1);
        wait_idle();
        program_settings(make_settings(MODE_BIPHASE, 16'd1, 16'd563, 16'd562, 16'd1688,
                                       16'd6737, 8'd9, 8'd17));
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h00000, 1'b1);
        wait_idle();
        program_settings(make_settings(MODE_BIPHASE, 16'hFFFF, 16'd563, 16'd562, 16'd1688,
                                       16'hFFFF, 8'd9, 8'd17));
        send_item(KIND_BIT, 17'h00000, 1'b0);
        send_item(KIND_BIT, 17'h00000, 1'b1);

        // Random settings per phase, random items within each phase
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            wait_idle();
            mode = ($urandom_range(0, 11) == 0) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
            case ($urandom_range(0, 19))
                0:       period = 16'd0;
                1:       period = 16'($urandom_range(1, 255));
                2:       period = 16'd256;
                3:       period = 16'hFFFF;
                default: period = 16'($urandom_range(256, 65535));
            endcase
            program_settings(make_settings(mode, pick_u16(), pick_u16(), pick_u16(),
                                           pick_u16(), period, 8'(pick_u16()),
                                           8'(pick_u16())));
            burst = $urandom_range(15, 60);
            // hold the receiver off long enough to back the pipeline up
            if (phase == 3 || phase == 14)
            begin
                stall_request = 1'b1;
                burst         = 80;
            end
            repeat (burst)
            begin
                case ($urandom_range(0, 7))
                    0:       raw = 17'h10000;
                    1:       raw = 17'h0FFFF;
                    2:       raw = '0;
                    3:       raw = '1;
                    default: raw = RAW_W'($urandom);
                endcase
                send_item($urandom_range(0, 1) ? KIND_BIT : KIND_RAW, raw, 1'($urandom));
            end
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/irenc_pkg.sv
sv/irenc_if.sv
sv/irenc_cfg.sv
sv/irenc_front.sv
sv/irenc_cell.sv
sv/irenc_out.sv
sv/ir_bit_to_mark_space_encoder.sv
sim/irenc_segment_checker.sv
sim/tb_ir_bit_to_mark_space_encoder.sv
